### rtl/bmhq_pkg.sv
// bmhq_pkg: shared constants, codes and types of the binary min-heap queue
// used by the channel interfaces, the heap controller and the top level
// depends on nothing
`default_nettype none

package bmhq_pkg;

  // sizing of the heap store
  localparam int CAPACITY = 255;
  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 16;
  localparam int DEPTH    = CAPACITY + 1;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = ADDR_W;
  localparam int KID_W    = ADDR_W + 1;
  localparam int ENTRY_W  = PRIO_W + DATA_W;

  // channel field widths
  localparam int MODE_W      = 2;
  localparam int IN_DATA_W   = 32;
  localparam int IN_PRIO_W   = 16;
  localparam int OUT_DATA_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_W     = 8;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [PRIO_W-1:0]     prio_t;
  typedef logic [OUT_DATA_W-1:0] odata_t;
  typedef logic [TOTAL_W-1:0]    total_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [KID_W-1:0]      kid_t;

  typedef struct packed {
    prio_t prio;
    data_t data;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    data_t             data;
    prio_t             prio;
  } req_t;

  typedef struct packed {
    odata_t              popped_data;
    logic [STATUS_W-1:0] status;
    total_t              entry_total;
    logic                is_empty;
  } res_t;

  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } ram_req_t;

endpackage

`default_nettype wire

### rtl/bmhq_if.sv
// bmhq_in_if / bmhq_out_if: valid-ready channels of the heap queue
// depends on bmhq_pkg for field widths
`default_nettype none

interface bmhq_in_if;
  logic                                valid;
  logic                                ready;
  logic [bmhq_pkg::MODE_W-1:0]         mode;
  logic [bmhq_pkg::IN_DATA_W-1:0]      item_data;
  logic [bmhq_pkg::IN_PRIO_W-1:0]      item_priority;

  modport source (output valid, output mode, output item_data, output item_priority,
                  input ready);
  modport sink   (input valid, input mode, input item_data, input item_priority,
                  output ready);
endinterface

interface bmhq_out_if;
  logic                                valid;
  logic                                ready;
  logic [bmhq_pkg::OUT_DATA_W-1:0]     popped_data;
  logic [bmhq_pkg::STATUS_W-1:0]       status;
  logic [bmhq_pkg::TOTAL_W-1:0]        entry_total;
  logic                                is_empty;

  modport source (output valid, output popped_data, output status, output entry_total,
                  output is_empty, input ready);
  modport sink   (input valid, input popped_data, input status, input entry_total,
                  input is_empty, output ready);
endinterface

`default_nettype wire

### rtl/bmhq_ram.sv
// bmhq_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/bmhq_ctrl.sv
// bmhq_ctrl: heap sequencer, walks sift-up and sift-down over the heap ram
// depends on bmhq_pkg; drives one bmhq_ram through a ram_req_t bundle
`default_nettype none

module bmhq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req_valid,
  output      logic               req_ready,
  input  wire bmhq_pkg::req_t     req,
  output      logic               res_valid,
  input  wire logic               res_ready,
  output      bmhq_pkg::res_t     res,
  output      bmhq_pkg::ram_req_t ram,
  input  wire bmhq_pkg::entry_t   ram_rd_data
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_UP_CMP   = 8'b0000_0010,
    ST_POP_TOP  = 8'b0000_0100,
    ST_POP_LAST = 8'b0000_1000,
    ST_DN_L     = 8'b0001_0000,
    ST_DN_R     = 8'b0010_0000,
    ST_PLACE    = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t                               state_r, state_nxt;
  bmhq_pkg::cnt_t                       count_r, count_nxt;
  bmhq_pkg::cnt_t                       left_r, left_nxt;
  bmhq_pkg::addr_t                      pos_r, pos_nxt;
  bmhq_pkg::entry_t                     moved_r, moved_nxt;
  bmhq_pkg::entry_t                     lkid_r, lkid_nxt;
  bmhq_pkg::odata_t                     popped_r, popped_nxt;
  logic [bmhq_pkg::STATUS_W-1:0]        status_r, status_nxt;

  // helpers for index arithmetic
  bmhq_pkg::kid_t   kid_l;
  bmhq_pkg::kid_t   left_ext;
  bmhq_pkg::addr_t  parent;
  bmhq_pkg::cnt_t   count_inc;
  bmhq_pkg::entry_t pick;
  bmhq_pkg::addr_t  pick_idx;
  bmhq_pkg::kid_t   pick_kid;

  assign kid_l     = {pos_r, 1'b0};
  assign left_ext  = bmhq_pkg::kid_t'(left_r);
  assign parent    = pos_r >> 1;
  assign count_inc = count_r + bmhq_pkg::cnt_t'(1);

  // child chosen for the sift-down step: smaller key, left wins a tie
  always_comb begin
    pick     = ram_rd_data;
    pick_idx = kid_l[bmhq_pkg::ADDR_W-1:0];
    if (state_r == ST_DN_R) begin
      if (lkid_r.prio > ram_rd_data.prio) begin
        pick     = ram_rd_data;
        pick_idx = kid_l[bmhq_pkg::ADDR_W-1:0] + bmhq_pkg::addr_t'(1);
      end else begin
        pick     = lkid_r;
        pick_idx = kid_l[bmhq_pkg::ADDR_W-1:0];
      end
    end
  end

  assign pick_kid = {pick_idx, 1'b0};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    moved_nxt   = moved_r;
    lkid_nxt    = lkid_r;
    popped_nxt  = popped_r;
    status_nxt  = status_r;
    ram         = '0;
    req_ready   = 1'b0;
    res_valid   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          popped_nxt = '0;
          status_nxt = bmhq_pkg::STATUS_OK;
          state_nxt  = ST_DONE;
          unique case (req.mode)
            bmhq_pkg::MODE_INSERT: begin
              if (count_r >= bmhq_pkg::cnt_t'(bmhq_pkg::CAPACITY)) begin
                status_nxt = bmhq_pkg::STATUS_FULL;
              end else begin
                count_nxt = count_inc;
                moved_nxt = '{prio: req.prio, data: req.data};
                pos_nxt   = bmhq_pkg::addr_t'(count_inc);
                if (count_r == '0) begin
                  state_nxt = ST_PLACE;
                end else begin
                  ram.rd_en   = 1'b1;
                  ram.rd_addr = bmhq_pkg::addr_t'(count_inc >> 1);
                  state_nxt   = ST_UP_CMP;
                end
              end
            end
            bmhq_pkg::MODE_POP: begin
              if (count_r == '0) begin
                status_nxt = bmhq_pkg::STATUS_EMPTY;
              end else begin
                count_nxt   = count_r - bmhq_pkg::cnt_t'(1);
                left_nxt    = count_r - bmhq_pkg::cnt_t'(1);
                ram.rd_en   = 1'b1;
                ram.rd_addr = bmhq_pkg::addr_t'(1);
                state_nxt   = ST_POP_TOP;
              end
            end
            bmhq_pkg::MODE_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // unused code leaves the heap alone
            end
          endcase
        end
      end

      // new key against its parent, parent moves down while it is larger
      ST_UP_CMP: begin
        if (moved_r.prio < ram_rd_data.prio) begin
          ram.wr_en   = 1'b1;
          ram.wr_addr = pos_r;
          ram.wr_data = ram_rd_data;
          pos_nxt     = parent;
          if (parent == bmhq_pkg::addr_t'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            ram.rd_en   = 1'b1;
            ram.rd_addr = parent >> 1;
          end
        end else begin
          ram.wr_en   = 1'b1;
          ram.wr_addr = pos_r;
          ram.wr_data = moved_r;
          state_nxt   = ST_DONE;
        end
      end

      // root payload out, then fetch the last entry
      ST_POP_TOP: begin
        popped_nxt  = bmhq_pkg::odata_t'(ram_rd_data.data);
        ram.rd_en   = 1'b1;
        ram.rd_addr = bmhq_pkg::addr_t'(left_r + bmhq_pkg::cnt_t'(1));
        state_nxt   = ST_POP_LAST;
      end

      ST_POP_LAST: begin
        moved_nxt = ram_rd_data;
        pos_nxt   = bmhq_pkg::addr_t'(1);
        if (left_r < bmhq_pkg::cnt_t'(2)) begin
          state_nxt = ST_PLACE;
        end else begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = bmhq_pkg::addr_t'(2);
          state_nxt   = ST_DN_L;
        end
      end

      // left child in hand; fetch the right one if it exists, then sift down through the smaller child
      ST_DN_L, ST_DN_R: begin
        lkid_nxt = ram_rd_data;
        if (state_r == ST_DN_L && (kid_l + bmhq_pkg::kid_t'(1)) <= left_ext) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = kid_l[bmhq_pkg::ADDR_W-1:0] + bmhq_pkg::addr_t'(1);
          state_nxt   = ST_DN_R;
        end else if (moved_r.prio <= pick.prio) begin
          state_nxt = ST_PLACE;
        end else begin
          ram.wr_en   = 1'b1;
          ram.wr_addr = pos_r;
          ram.wr_data = pick;
          pos_nxt     = pick_idx;
          if (pick_kid > left_ext) begin
            state_nxt = ST_PLACE;
          end else begin
            ram.rd_en   = 1'b1;
            ram.rd_addr = pick_kid[bmhq_pkg::ADDR_W-1:0];
            state_nxt   = ST_DN_L;
          end
        end
      end

      ST_PLACE: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = pos_r;
        ram.wr_data = moved_r;
        state_nxt   = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result fields, count taken after the operation
  assign res = '{popped_data: popped_r,
                 status:      status_r,
                 entry_total: bmhq_pkg::total_t'(count_r),
                 is_empty:    (count_r == '0)};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    pos_r    <= pos_nxt;
    moved_r  <= moved_nxt;
    lkid_r   <= lkid_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

### rtl/binary_min_heap_queue.sv
// binary_min_heap_queue: top level of the min-heap priority queue
// depends on bmhq_pkg, bmhq_if, bmhq_ram and bmhq_ctrl
//
//  channel   direction  handshake            fields
//  in_chan   sink       valid/ready          mode, item_data, item_priority
//  out_chan  source     valid/ready          popped_data, status, entry_total, is_empty
//
// one item at a time: an insert reads one parent for each level the key is compared against, a pop reads
// the root, the last entry and one or two children for each level whose children are compared; clear and
// rejected operations touch no ram. the ram's single read port sets the pace.
// synchronous active-low reset empties the heap; store contents are left as they are.
// a result waiting in the output register does not block the next item's work.
`default_nettype none

module binary_min_heap_queue (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bmhq_in_if.sink      in_chan,
  bmhq_out_if.source   out_chan
);

  bmhq_pkg::req_t     req;
  bmhq_pkg::res_t     res;
  bmhq_pkg::ram_req_t ram;
  bmhq_pkg::entry_t   ram_rd_data;
  logic               req_ready;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_r;
  bmhq_pkg::res_t     out_res_r;

  // input fields cast to the stored widths
  assign req = '{mode: in_chan.mode,
                 data: bmhq_pkg::data_t'(in_chan.item_data),
                 prio: bmhq_pkg::prio_t'(in_chan.item_priority)};
  assign in_chan.ready = req_ready;

  bmhq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_chan.valid),
    .req_ready   (req_ready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram         (ram),
    .ram_rd_data (ram_rd_data)
  );

  bmhq_ram #(
    .WIDTH (bmhq_pkg::ENTRY_W),
    .DEPTH (bmhq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (ram.wr_data),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.popped_data = out_res_r.popped_data;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.entry_total = out_res_r.entry_total;
  assign out_chan.is_empty    = out_res_r.is_empty;

endmodule

`default_nettype wire

### tb/sv/heap_queue_checker.sv
`timescale 1ns / 1ps
// heap_queue_checker: watches both channels of the min-heap queue, keeps its own heap
// copy to predict each result, and compares every returned item field by field
// depends on bmhq_pkg and the bmhq_in_if / bmhq_out_if interfaces

module heap_queue_checker
  import bmhq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bmhq_in_if   in_mon,
  bmhq_out_if  out_mon,
  output int   fail_count,
  output int   pending_total
);

  localparam int PRINT_MAX = 100;

  // shadow heap, one-based like the block's store
  entry_t      heap_slots [1:CAPACITY];
  int unsigned held;
  res_t        results_due [$];

  initial begin
    fail_count    = 0;
    pending_total = 0;
    held          = 0;
  end

  // one printed line per mismatch, quiet after the first hundred
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_MAX)
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
  endtask

  // apply one operation to the shadow heap and return the result it must produce
  function automatic res_t heap_apply(input logic [MODE_W-1:0] op, input data_t d,
                                      input prio_t p);
    res_t   r;
    entry_t moved;
    int     pos;
    int     kid;
    int     remain;
    bit     settled;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      MODE_INSERT: begin
        if (held >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          // sift up, stopping on an equal key
          pos = held + 1;
          while (pos > 1 && p < heap_slots[pos / 2].prio) begin
            heap_slots[pos] = heap_slots[pos / 2];
            pos = pos / 2;
          end
          heap_slots[pos].prio = p;
          heap_slots[pos].data = d;
          held++;
        end
      end
      MODE_POP: begin
        if (held == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.popped_data = heap_slots[1].data;
          moved   = heap_slots[held];
          remain  = held - 1;
          pos     = 1;
          settled = 1'b0;
          // sift the last entry down through the smaller child, left on a tie
          while (!settled) begin
            kid = pos * 2;
            if (kid > remain) begin
              settled = 1'b1;
            end else begin
              if (kid + 1 <= remain && heap_slots[kid].prio > heap_slots[kid + 1].prio)
                kid++;
              if (moved.prio <= heap_slots[kid].prio) begin
                settled = 1'b1;
              end else begin
                heap_slots[pos] = heap_slots[kid];
                pos = kid;
              end
            end
          end
          heap_slots[pos] = moved;
          held = remain;
        end
      end
      MODE_CLEAR: held = 0;
      default: ;
    endcase
    r.entry_total = held[TOTAL_W-1:0];
    r.is_empty    = (held == 0);
    return r;
  endfunction

  // predict on each accepted input item, compare on each accepted result item
  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      held = 0;
      results_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        results_due.push_back(heap_apply(in_mon.mode, in_mon.item_data,
                                         in_mon.item_priority));
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with none expected", out_mon.popped_data, '0);
        end else begin
          want = results_due.pop_front();
          if (out_mon.popped_data !== want.popped_data)
            report_mismatch("popped_data", out_mon.popped_data, want.popped_data);
          if (out_mon.status !== want.status)
            report_mismatch("status", 32'(out_mon.status), 32'(want.status));
          if (out_mon.entry_total !== want.entry_total)
            report_mismatch("entry_total", 32'(out_mon.entry_total),
                            32'(want.entry_total));
          if (out_mon.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(out_mon.is_empty), 32'(want.is_empty));
        end
      end
    end
    pending_total = results_due.size();
  end

endmodule

### tb/sv/tb_binary_min_heap_queue.sv
`timescale 1ns / 1ps
// tb_binary_min_heap_queue: clock, reset and stimulus for the min-heap queue, with
// random gaps on both channels; checking is done by heap_queue_checker beside the dut
// depends on bmhq_pkg, bmhq_if, binary_min_heap_queue and heap_queue_checker

module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_total;
  int   items_sent;
  int   cycle_count;
  int   ready_hold;
  bit   calm;

  bmhq_in_if  in_chan ();
  bmhq_out_if out_chan ();

  binary_min_heap_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  heap_queue_checker queue_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending_total (pending_total)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short spans, a few long ones
  function automatic int random_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // keys: full range, a narrow band for ties, or the extremes
  function automatic prio_t random_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return prio_t'($urandom);
    if (r < 80) return prio_t'($urandom_range(0, 7));
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // result side back-pressure
  initial out_chan.ready = 1'b0;
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (calm) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= 35);
      ready_hold = random_span();
    end
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // present one item after a random gap; called and returns at a falling edge
  task automatic send_item(input logic [MODE_W-1:0] m, input data_t d, input prio_t p);
    int gap;
    gap = calm ? 0 : random_span();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.mode          <= m;
    in_chan.item_data     <= d;
    in_chan.item_priority <= p;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // clear, fill past capacity, then drain past empty
  task automatic fill_and_drain(input int prio_hi);
    calm = ($urandom_range(0, 1) != 0);
    send_item(MODE_CLEAR, data_t'($urandom), prio_t'($urandom));
    repeat (CAPACITY + 3)
      send_item(MODE_INSERT, data_t'($urandom), prio_t'($urandom_range(0, prio_hi)));
    repeat (CAPACITY + 3)
      send_item(MODE_POP, data_t'($urandom), prio_t'($urandom));
  endtask

  // runs leaning toward insert or pop so the heap grows deep and shrinks again
  task automatic random_mix(input int stop_at);
    int              run_len;
    int              insert_pct;
    int              r;
    logic [MODE_W-1:0] m;
    while (items_sent < stop_at) begin
      run_len    = $urandom_range(1, 40);
      insert_pct = ($urandom_range(0, 1) != 0) ? 80 : 35;
      calm       = ($urandom_range(0, 4) == 0);
      repeat (run_len) begin
        r = $urandom_range(0, 99);
        if (r < 2)               m = MODE_CLEAR;
        else if (r < 4)          m = MODE_UNUSED;
        else if (r < insert_pct) m = MODE_INSERT;
        else                     m = MODE_POP;
        send_item(m, data_t'($urandom), random_prio());
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    in_chan.valid         = 1'b0;
    in_chan.mode          = MODE_INSERT;
    in_chan.item_data     = '0;
    in_chan.item_priority = '0;
    items_sent            = 0;
    ready_hold            = 0;
    calm                  = 1'b0;
    rst_n                 = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty-heap cases, extreme fields, equal keys, unused mode, clear
    send_item(MODE_POP,    32'h0000_0000, 16'h0000);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(MODE_CLEAR,  32'h0000_0000, 16'h0000);
    send_item(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(MODE_INSERT, 32'h0000_0000, 16'h0000);
    send_item(MODE_INSERT, 32'h0000_0001, 16'h0000);
    send_item(MODE_INSERT, 32'hA5A5_A5A5, 16'h8000);
    send_item(MODE_INSERT, 32'h5A5A_5A5A, 16'h7FFF);
    send_item(MODE_INSERT, 32'h0000_0002, 16'h0000);
    send_item(MODE_UNUSED, 32'h1234_5678, 16'h0001);
    repeat (3) send_item(MODE_POP, 32'h0, 16'h0);
    send_item(MODE_INSERT, 32'h0000_0003, 16'h0005);
    send_item(MODE_INSERT, 32'h0000_0004, 16'h0005);
    send_item(MODE_INSERT, 32'h0000_0005, 16'h0005);
    send_item(MODE_INSERT, 32'h0000_0006, 16'h0005);
    repeat (3) send_item(MODE_POP, 32'h0, 16'h0);
    send_item(MODE_CLEAR,  32'hFFFF_FFFF, 16'hFFFF);
    send_item(MODE_POP,    32'hFFFF_FFFF, 16'hFFFF);
    send_item(MODE_INSERT, 32'h8000_0000, 16'h0001);
    send_item(MODE_POP,    32'h0, 16'h0);

    // random phases with full and empty heap in between
    fill_and_drain(15);
    random_mix(1000);
    fill_and_drain(16'hFFFF);
    random_mix(1950);

    in_chan.valid <= 1'b0;
    calm = 1'b1;
    while (pending_total != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending_total == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
